// File: sv/alsd_pkg.sv
package alsd_pkg;

  // Field widths fixed by the item and register formats
  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned LedCntW = 6;
  localparam int unsigned CfgIdxW = 2;

  // Defaults for the top-level parameters
  localparam int unsigned MaxLedsDef    = 32;
  localparam int unsigned BitsPerLedDef = 24;

  // Register reset values
  localparam logic [CfgW-1:0]    BitPeriodRst = 16'd90;
  localparam logic [CfgW-1:0]    HighOneRst   = 16'd55;
  localparam logic [CfgW-1:0]    HighZeroRst  = 16'd25;
  localparam logic [LedCntW-1:0] LedCountRst  = 6'd28;

  // Shortest usable bit period
  localparam logic [CfgW-1:0] MinPeriod = 16'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegBitPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHighOne   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHighZero  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLedCount  = 2'd3;

  typedef enum logic [ModeW-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    op_e                op;
    logic               wr_ok;
    logic               start_ok;
    logic [IdxW-1:0]    idx;
    logic [ColorW-1:0]  color;
  } item_t;

  // Waveform timing registers seen by the back
  typedef struct packed {
    logic [CfgW-1:0] bit_period;
    logic [CfgW-1:0] high_one;
    logic [CfgW-1:0] high_zero;
  } timing_cfg_t;

endpackage

// File: sv/alsd_if.sv
interface alsd_in_if import alsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [IdxW-1:0]   led_index;
  logic [ColorW-1:0] color;

  modport source (output valid, mode, led_index, color, input ready);
  modport sink   (input valid, mode, led_index, color, output ready);
endinterface

interface alsd_out_if import alsd_pkg::*; ();
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, line_level, busy_res, frame_done, input ready);
  modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface

// File: sv/alsd_front.sv
module alsd_front import alsd_pkg::*; #(
  parameter int unsigned EcW = 6
) (
  alsd_in_if.sink     in_if,
  input  logic [EcW-1:0] eff_count_i,
  input  logic        clr_busy_i,
  input  logic        push_ready_i,
  output logic        push_valid_o,
  output item_t       push_item_o
);

  localparam int unsigned CmpW = (EcW > IdxW) ? EcW : IdxW;

  // Hold off the upstream while the colour store is being cleared
  assign in_if.ready  = push_ready_i & ~clr_busy_i;
  assign push_valid_o = in_if.valid & ~clr_busy_i;

  always_comb begin
    push_item_o.op       = op_e'(in_if.mode);
    push_item_o.wr_ok    = CmpW'(in_if.led_index) < CmpW'(eff_count_i);
    push_item_o.start_ok = eff_count_i != '0;
    push_item_o.idx      = in_if.led_index;
    push_item_o.color    = in_if.color;
  end

endmodule

// File: sv/alsd_queue.sv
module alsd_queue import alsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned Depth = 2;

  item_t      entry_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = count_q != 2'(Depth);
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_item_o   = entry_q[rd_ptr_q];

  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: sv/alsd_back.sv
module alsd_back import alsd_pkg::*; #(
  parameter int unsigned MaxLeds    = MaxLedsDef,
  parameter int unsigned BitsPerLed = BitsPerLedDef,
  parameter int unsigned EcW        = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  timing_cfg_t    timing_i,
  input  logic [EcW-1:0] eff_count_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  item_t          pop_item_i,
  output logic           clr_busy_o,
  alsd_out_if.source     out_if
);

  localparam int unsigned LpW  = (MaxLeds > 1) ? $clog2(MaxLeds) : 1;
  localparam int unsigned BpW  = $clog2(BitsPerLed);
  localparam int unsigned PadW = 1 << BpW;
  localparam int unsigned LcW  = (LpW + 1 > EcW) ? LpW + 1 : EcW;
  localparam logic [BpW-1:0] BpLast  = BpW'(BitsPerLed - 1);
  localparam logic [LpW-1:0] LastLed = LpW'(MaxLeds - 1);

  // Colour store and its registered read port
  logic [ColorW-1:0] mem [MaxLeds];
  logic [ColorW-1:0] rd_data_q;
  logic              mem_we;
  logic [LpW-1:0]    mem_waddr;
  logic [ColorW-1:0] mem_wdata;

  // Clearing pass after reset
  logic           clr_active_q, clr_active_d;
  logic [LpW-1:0] clr_addr_q, clr_addr_d;

  // Frame state
  logic            sending_q, sending_d;
  logic [LpW-1:0]  lp_q, lp_d;
  logic [BpW-1:0]  bp_q, bp_d;
  logic [CfgW-1:0] tick_q, tick_d;
  logic            line_q, line_d;

  // Result register
  logic out_valid_q;
  logic level_q, level_d;
  logic busy_q;
  logic done_q, done_d;

  logic              step;
  logic [BpW-1:0]    bit_pos;
  logic [PadW-1:0]   padded;
  logic              cur_bit;
  logic [CfgW-1:0]   high_time;
  logic [CfgW-1:0]   period_eff;
  logic [CfgW-1:0]   tick_inc;
  logic              tick_level;
  logic              bit_end;
  logic              last_led;

  assign clr_busy_o  = clr_active_q;
  assign pop_ready_o = ~clr_active_q & (~out_valid_q | out_if.ready);
  assign step        = pop_valid_i & pop_ready_o;

  // Waveform datapath for the current bit
  always_comb begin
    bit_pos    = BpLast - bp_q;
    padded     = PadW'(rd_data_q);
    cur_bit    = padded[bit_pos];
    high_time  = cur_bit ? timing_i.high_one : timing_i.high_zero;
    tick_level = tick_q < high_time;
    tick_inc   = tick_q + 16'd1;
    period_eff = (timing_i.bit_period < MinPeriod) ? MinPeriod : timing_i.bit_period;
    bit_end    = tick_inc >= period_eff;
    last_led   = (LcW'(lp_q) + LcW'(1)) >= LcW'(eff_count_i);
  end

  always_comb begin
    sending_d = sending_q;
    lp_d      = lp_q;
    bp_d      = bp_q;
    tick_d    = tick_q;
    line_d    = line_q;
    level_d   = sending_q & line_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = LpW'(pop_item_i.idx);
    mem_wdata = pop_item_i.color;
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;

    if (clr_active_q) begin
      mem_we     = 1'b1;
      mem_waddr  = clr_addr_q;
      mem_wdata  = '0;
      clr_addr_d = clr_addr_q + LpW'(1);
      if (clr_addr_q == LastLed) begin
        clr_active_d = 1'b0;
      end
    end else if (step) begin
      case (pop_item_i.op)
        OP_WRITE: begin
          mem_we = ~sending_q & pop_item_i.wr_ok;
        end
        OP_START: begin
          if (!sending_q && pop_item_i.start_ok) begin
            sending_d = 1'b1;
            lp_d      = '0;
            bp_d      = '0;
            tick_d    = '0;
            line_d    = 1'b0;
          end
        end
        OP_TICK: begin
          level_d = 1'b0;
          if (sending_q) begin
            level_d = tick_level;
            line_d  = tick_level;
            tick_d  = tick_inc;
            if (bit_end) begin
              tick_d = '0;
              if (bp_q == BpLast) begin
                bp_d = '0;
                if (last_led) begin
                  sending_d = 1'b0;
                  lp_d      = '0;
                  line_d    = 1'b0;
                  done_d    = 1'b1;
                end else begin
                  lp_d = lp_q + LpW'(1);
                end
              end else begin
                bp_d = bp_q + BpW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      sending_q    <= 1'b0;
      lp_q         <= '0;
      bp_q         <= '0;
      tick_q       <= '0;
      line_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      sending_q    <= sending_d;
      lp_q         <= lp_d;
      bp_q         <= bp_d;
      tick_q       <= tick_d;
      line_q       <= line_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      level_q <= level_d;
      busy_q  <= sending_d;
      done_q  <= done_d;
    end
  end

  // Colour store: one write port, one registered read of the LED in use next
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[lp_d];
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.line_level = level_q;
  assign out_if.busy_res   = busy_q;
  assign out_if.frame_done = done_q;

endmodule

// File: sv/addressable_led_strip_driver_core.sv
// Addressable RGB LED chain driver: colour store plus one-wire bit timing.
//
// Channels: in_if carries items (mode, led_index, color); mode write stores a
// colour, start arms a frame, tick advances the waveform by one timer clock.
// out_if returns exactly one item per input item: the line level, whether a
// frame is in flight, and a done flag on the tick that ends the last bit.
// cfg_we_i/cfg_index_i/cfg_data_i write bit_period, high_one, high_zero and
// led_count; write them only while no item is in flight.
//
// Throughput: one item per clock while out_if does not stall, set by the tick
// step in the back end. Path: an item taken on in_if is registered in the queue,
// then popped by the back end into its result register, which raises
// out_if.valid; a stall on out_if can hold the pop in between.
//
// Reset: all frame state clears and the colour store is swept to black, one
// LED per cycle over all MAX_LEDS entries; in_if.ready stays low for that sweep.
// A stall on out_if holds the result register; the two-entry queue keeps
// taking items until it fills, then in_if.ready drops.
module addressable_led_strip_driver_core import alsd_pkg::*; #(
  parameter int unsigned MAX_LEDS     = MaxLedsDef,
  parameter int unsigned BITS_PER_LED = BitsPerLedDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  alsd_in_if.sink            in_if,
  alsd_out_if.source         out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Width that holds the effective LED count, 0..MAX_LEDS
  localparam int unsigned EcW   = $clog2(MAX_LEDS + 1);
  localparam int unsigned LcCmpW = (LedCntW > EcW) ? LedCntW : EcW;

  // Configuration registers
  logic [CfgW-1:0]    bit_period_q;
  logic [CfgW-1:0]    high_one_q;
  logic [CfgW-1:0]    high_zero_q;
  logic [LedCntW-1:0] led_count_q;

  timing_cfg_t    timing;
  logic [EcW-1:0] eff_count;

  // Queue hookup between the front and the back
  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;
  logic  clr_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= BitPeriodRst;
      high_one_q   <= HighOneRst;
      high_zero_q  <= HighZeroRst;
      led_count_q  <= LedCountRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBitPeriod: bit_period_q <= cfg_data_i;
        RegHighOne:   high_one_q   <= cfg_data_i;
        RegHighZero:  high_zero_q  <= cfg_data_i;
        RegLedCount:  led_count_q  <= cfg_data_i[LedCntW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Saturate the LED count at the store depth
  always_comb begin
    if (LcCmpW'(led_count_q) > LcCmpW'(MAX_LEDS)) begin
      eff_count = EcW'(MAX_LEDS);
    end else begin
      eff_count = EcW'(led_count_q);
    end
    timing.bit_period = bit_period_q;
    timing.high_one   = high_one_q;
    timing.high_zero  = high_zero_q;
  end

  // Front: take items and classify them
  alsd_front #(
    .EcW (EcW)
  ) u_front (
    .in_if        (in_if),
    .eff_count_i  (eff_count),
    .clr_busy_i   (clr_busy),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  // Short queue so front and back stall independently
  alsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back: colour store, bit timing and the result register
  alsd_back #(
    .MaxLeds    (MAX_LEDS),
    .BitsPerLed (BITS_PER_LED),
    .EcW        (EcW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timing_i    (timing),
    .eff_count_i (eff_count),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .clr_busy_o  (clr_busy),
    .out_if      (out_if)
  );

endmodule
